// ----- hdl/assert_macros.svh -----
// Assertion macros for the checker file of the hash table engine.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent property.
`define CHT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// A signal holds in the cycle after a condition.
`define CHT_ASSERT_HOLD(lbl, cond, sig, msg) \
	`CHT_ASSERT(lbl, (cond) |=> $stable(sig), msg)

`endif

// ----- hdl/cht_pkg.sv -----
// Package of the chained hash table engine: word types, codes, sizes,
// key cleaning and key hash. No dependencies.
`default_nettype none

package cht_pkg;

	localparam int CHT_BUCKETS     = 1024;
	localparam int CHT_POOL_NODES  = 1024;
	localparam int CHT_QUEUE_DEPTH = 2;

	localparam int KEY_W  = 24;
	localparam int VAL_W  = 24;
	localparam int STAT_W = 2;

	// Hash: h = h * 37 + char over the key characters.
	localparam int HASH_MULT = 37;
	localparam int HASH_W    = 19;	// 255 * (37*37 + 37 + 1) fits
	localparam logic [HASH_W-1:0] MULT_H    = HASH_W'(HASH_MULT);
	localparam logic [HASH_W-1:0] MULT_SQ_H = HASH_W'(HASH_MULT * HASH_MULT);

	// Remainder unit: reciprocal multiply, quotient times bucket count,
	// subtract; one register stage each.
	localparam int MOD_STEPS = 3;
	localparam int MOD_CNT_W = $clog2(MOD_STEPS + 1);

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic             command;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] left_value;
		logic [VAL_W-1:0] right_value;
	} in_word_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [VAL_W-1:0]  found_left;
		logic [VAL_W-1:0]  found_right;
	} out_word_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_HEAD,
		BK_NODE,
		BK_RESULT
	} back_state_t;

	// Characters from the first zero character on are dropped.
	function automatic logic [KEY_W-1:0] clean_key(input logic [KEY_W-1:0] k);
		if (k[23:16] == 8'h00) begin
			return '0;
		end else if (k[15:8] == 8'h00) begin
			return {k[23:16], 16'h0000};
		end
		return k;
	endfunction

	// Hash of a cleaned key; the character count sets the polynomial.
	function automatic logic [HASH_W-1:0] key_hash(input logic [KEY_W-1:0] k);
		logic [HASH_W-1:0] c0;
		logic [HASH_W-1:0] c1;
		logic [HASH_W-1:0] c2;
		c0 = HASH_W'(k[23:16]);
		c1 = HASH_W'(k[15:8]);
		c2 = HASH_W'(k[7:0]);
		if (c0 == '0) begin
			return '0;
		end else if (c1 == '0) begin
			return c0;
		end else if (c2 == '0) begin
			return c0 * MULT_H + c1;
		end
		return c0 * MULT_SQ_H + c1 * MULT_H + c2;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/cht_front.sv -----
// Front end: takes request words, cleans the key, hashes it and reduces
// the hash to a bucket index in the remainder steps. Uses cht_pkg.
`default_nettype none

module cht_front import cht_pkg::*; #(
	parameter int BUCKETS = CHT_BUCKETS,
	parameter int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire in_word_t      req,
	input  wire logic          clearing,
	output logic               q_wr,
	output in_word_t           q_word,
	output logic [BW-1:0]      q_bucket,
	input  wire logic          q_full
);

	// hash mod BUCKETS: q = (x * RECIP) >> SH, exact for any HASH_W-bit x
	// since RECIP overshoots 2^SH / BUCKETS by less than one
	localparam int SH     = HASH_W + $clog2(BUCKETS);
	localparam int MW     = HASH_W + 1;
	localparam int PROD_W = HASH_W + MW;
	localparam logic [MW-1:0] RECIP =
		MW'(((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
	localparam logic [HASH_W-1:0] BKT_H = HASH_W'(BUCKETS);

	logic                 busy_q;
	logic [MOD_CNT_W-1:0] step_q;
	in_word_t             item_q;
	logic [HASH_W-1:0]    x_q;
	logic [PROD_W-1:0]    prod_q;
	logic [HASH_W-1:0]    qb_q;
	logic [BW-1:0]        r_q;
	logic [PROD_W-SH-1:0] quot;
	logic                 done;
	logic                 accept;
	logic [KEY_W-1:0]     key_clean;

	assign done      = (step_q == MOD_CNT_W'(MOD_STEPS));
	assign q_wr      = busy_q && done && !q_full;
	assign req_ready = !clearing && (!busy_q || q_wr);
	assign accept    = req_valid && req_ready;
	assign key_clean = clean_key(req.key);
	assign q_word    = item_q;
	assign q_bucket  = r_q;
	assign quot      = prod_q[PROD_W-1:SH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (q_wr) begin
			busy_q <= 1'b0;
		end else if (busy_q && !done) begin
			step_q <= step_q + MOD_CNT_W'(1);
		end
	end

	// x_q holds still while busy, so r_q is settled by the time done is set
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.command     <= req.command;
			item_q.key         <= key_clean;
			item_q.left_value  <= req.left_value;
			item_q.right_value <= req.right_value;
			x_q                <= key_hash(key_clean);
		end else if (busy_q && !done) begin
			prod_q <= PROD_W'(x_q) * PROD_W'(RECIP);
			qb_q   <= HASH_W'(quot) * BKT_H;
			r_q    <= BW'(x_q - qb_q);
		end
	end

endmodule

`default_nettype wire

// ----- hdl/cht_fifo.sv -----
// Small register queue between front and back end.
// Generic width and depth; no package dependency.
`default_nettype none

module cht_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             rd,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/cht_back.sv -----
// Back end: bucket head memory, node pool memory and the sequencer that
// runs inserts and chain walks, plus the result register. Uses cht_pkg.
`default_nettype none

module cht_back import cht_pkg::*; #(
	parameter int BUCKETS    = CHT_BUCKETS,
	parameter int POOL_NODES = CHT_POOL_NODES,
	parameter int BW         = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_empty,
	output logic               q_rd,
	input  wire in_word_t      q_word,
	input  wire logic [BW-1:0] q_bucket,
	output logic               clearing,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output out_word_t          rsp
);

	localparam int PW     = $clog2(POOL_NODES + 1);
	localparam int NW     = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
	localparam int NODE_W = KEY_W + 2 * VAL_W + PW;
	localparam logic [PW-1:0] EMPTY    = PW'(POOL_NODES);
	localparam logic [BW-1:0] CLR_LAST = BW'(BUCKETS - 1);

	back_state_t state_q;
	back_state_t state_d;

	logic [BW-1:0] clr_q;
	logic [PW-1:0] used_q;
	in_word_t      cur_q;
	logic [BW-1:0] bkt_q;
	out_word_t     res_q;
	out_word_t     res_d;
	logic          rsp_valid_q;
	out_word_t     rsp_q;

	logic [PW-1:0]     head_mem [BUCKETS];
	logic [PW-1:0]     head_rd_q;
	logic [NODE_W-1:0] node_mem [POOL_NODES];
	logic [NODE_W-1:0] node_rd_q;

	logic          head_we;
	logic [BW-1:0] head_waddr;
	logic [PW-1:0] head_wdata;
	logic          node_we;
	logic [NW-1:0] node_raddr;
	logic          res_we;
	logic          used_inc;
	logic          rsp_load;

	logic [KEY_W-1:0] nd_key;
	logic [VAL_W-1:0] nd_left;
	logic [VAL_W-1:0] nd_right;
	logic [PW-1:0]    nd_link;
	logic             is_insert;
	logic             pool_full;
	logic             head_end;
	logic             hit;
	logic             link_end;

	assign nd_key   = node_rd_q[NODE_W-1 -: KEY_W];
	assign nd_left  = node_rd_q[NODE_W-KEY_W-1 -: VAL_W];
	assign nd_right = node_rd_q[PW +: VAL_W];
	assign nd_link  = node_rd_q[PW-1:0];

	assign is_insert = (cur_q.command == CMD_INSERT);
	assign pool_full = (used_q >= EMPTY);
	assign head_end  = (head_rd_q >= EMPTY);
	assign hit       = (nd_key == cur_q.key);
	assign link_end  = (nd_link >= EMPTY);

	assign clearing  = (state_q == BK_CLEAR);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_CLEAR: begin
				if (clr_q == CLR_LAST) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (!q_empty) begin
					state_d = BK_HEAD;
				end
			end
			BK_HEAD: begin
				if (is_insert || head_end) begin
					state_d = BK_RESULT;
				end else begin
					state_d = BK_NODE;
				end
			end
			BK_NODE: begin
				if (hit || link_end) begin
					state_d = BK_RESULT;
				end
			end
			BK_RESULT: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_CLEAR;
		endcase
	end

	// per-state controls
	always_comb begin
		q_rd       = 1'b0;
		head_we    = 1'b0;
		head_waddr = bkt_q;
		head_wdata = used_q;
		node_we    = 1'b0;
		node_raddr = head_rd_q[NW-1:0];
		res_we     = 1'b0;
		res_d      = '0;
		used_inc   = 1'b0;
		rsp_load   = 1'b0;
		unique case (state_q)
			BK_CLEAR: begin
				head_we    = 1'b1;
				head_waddr = clr_q;
				head_wdata = EMPTY;
			end
			BK_IDLE: begin
				q_rd = !q_empty;
			end
			BK_HEAD: begin
				res_we = is_insert || head_end;
				if (is_insert) begin
					if (pool_full) begin
						res_d.status = ST_FULL;
					end else begin
						head_we      = 1'b1;
						node_we      = 1'b1;
						used_inc     = 1'b1;
						res_d.status = ST_OK;
					end
				end else begin
					res_d.status = ST_NOT_FOUND;
				end
			end
			BK_NODE: begin
				node_raddr = nd_link[NW-1:0];
				res_we     = hit || link_end;
				if (hit) begin
					res_d.status      = ST_OK;
					res_d.found_left  = nd_left;
					res_d.found_right = nd_right;
				end else begin
					res_d.status = ST_NOT_FOUND;
				end
			end
			BK_RESULT: begin
				rsp_load = !rsp_valid_q || rsp_ready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_q       <= '0;
			used_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				clr_q <= clr_q + BW'(1);
			end
			if (used_inc) begin
				used_q <= used_q + PW'(1);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			cur_q <= q_word;
			bkt_q <= q_bucket;
		end
		if (res_we) begin
			res_q <= res_d;
		end
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	// bucket heads: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_waddr] <= head_wdata;
		end
		head_rd_q <= head_mem[q_bucket];
	end

	// node pool: new node links to the old head
	always_ff @(posedge clk) begin
		if (node_we) begin
			node_mem[used_q[NW-1:0]] <=
				{cur_q.key, cur_q.left_value, cur_q.right_value, head_rd_q};
		end
		node_rd_q <= node_mem[node_raddr];
	end

endmodule

`default_nettype wire

// ----- hdl/chained_hash_table_engine.sv -----
// Chained hash table engine, top level: front end, queue and back end.
// Depends on cht_pkg, cht_front, cht_fifo and cht_back.
//
// Usage:
//   req channel (req_valid/req_ready/req): one in_word_t per command.
//     command CMD_INSERT adds key with its value pair at the head of the
//     key's bucket chain; CMD_SEARCH looks the key up (values ignored).
//   rsp channel (rsp_valid/rsp_ready/rsp): exactly one out_word_t per
//     command, in command order. status ST_OK, ST_NOT_FOUND or ST_FULL;
//     found values are zero unless a search hits.
// Flow: the front end cleans and hashes the key and reduces the hash in
//   the remainder steps; the back end reads the bucket head, then writes
//   the new node if the pool has room or walks the chain, one node read
//   per cycle from the node pool memory, and loads the result register.
// Throughput: the front end takes a new word only as it hands the last
//   one to the queue; the back end is bound by chain walks, one bucket
//   head read plus one pool read per node.
// Reset: arst_n clears control state; the bucket head memory is then swept
//   to empty, bucket by bucket, with req_ready held low.
// Stall: the result register holds rsp until taken; the two-entry queue
//   lets the front end keep accepting while the back end waits.
`default_nettype none

module chained_hash_table_engine import cht_pkg::*; #(
	parameter int BUCKETS    = CHT_BUCKETS,
	parameter int POOL_NODES = CHT_POOL_NODES
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	input  wire in_word_t req,
	output logic          rsp_valid,
	input  wire logic     rsp_ready,
	output out_word_t     rsp
);

	localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int QW  = $bits(in_word_t) + BW;

	logic          clearing;
	logic          f_wr;
	in_word_t      f_word;
	logic [BW-1:0] f_bucket;
	logic          q_full;
	logic          q_empty;
	logic          q_rd;
	logic [QW-1:0] q_data;
	in_word_t      q_word;
	logic [BW-1:0] q_bucket;

	assign q_word   = in_word_t'(q_data[$bits(in_word_t)-1:0]);
	assign q_bucket = q_data[QW-1 -: BW];

	cht_front #(
		.BUCKETS (BUCKETS),
		.BW      (BW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.clearing  (clearing),
		.q_wr      (f_wr),
		.q_word    (f_word),
		.q_bucket  (f_bucket),
		.q_full    (q_full)
	);

	cht_fifo #(
		.WIDTH (QW),
		.DEPTH (CHT_QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (f_wr),
		.wdata  ({f_bucket, f_word}),
		.full   (q_full),
		.rd     (q_rd),
		.rdata  (q_data),
		.empty  (q_empty)
	);

	cht_back #(
		.BUCKETS    (BUCKETS),
		.POOL_NODES (POOL_NODES),
		.BW         (BW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_rd      (q_rd),
		.q_word    (q_word),
		.q_bucket  (q_bucket),
		.clearing  (clearing),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// ----- hdl/cht_checker.sv -----
// Port-level checker for the chained hash table engine, bound to the top.
// Depends on cht_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cht_checker import cht_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      rsp_valid,
	input wire logic      rsp_ready,
	input wire out_word_t rsp
);

	logic legal_status;
	logic values_zero;

	assign legal_status = (rsp.status == ST_OK) || (rsp.status == ST_NOT_FOUND) ||
		(rsp.status == ST_FULL);
	assign values_zero  = (rsp.found_left == '0) && (rsp.found_right == '0);

	`CHT_ASSERT(a_rsp_valid_holds, rsp_valid && !rsp_ready |=> rsp_valid, "rsp_valid dropped")
	`CHT_ASSERT_HOLD(a_rsp_word_holds, rsp_valid && !rsp_ready, rsp, "rsp changed while stalled")
	`CHT_ASSERT(a_status_legal, rsp_valid |-> legal_status, "bad status code")
	`CHT_ASSERT(a_miss_zero, rsp_valid && rsp.status != ST_OK |-> values_zero, "values on a miss")

endmodule

bind chained_hash_table_engine cht_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

`default_nettype wire
